// File: rtl/lvp_pkg.sv
// ----------------------------------------------------------------------------
// lvp_pkg: shared types and constants of the latched video RAM and palette
// Request and result payloads, the decoded request that passes from the
// front end to the back end, and the color intensity table.
// ----------------------------------------------------------------------------
package lvp_pkg;

  localparam int FS_AW         = 16;
  localparam int PAL_AW        = 10;
  localparam int BANK_W        = 2;
  localparam int PENS_PER_BANK = 256;
  localparam int PEN_W         = $clog2(PENS_PER_BANK);

  localparam logic [3:0] REQ_WIN_RD   = 4'd0;
  localparam logic [3:0] REQ_WIN_WR   = 4'd1;
  localparam logic [3:0] REQ_LAT_RD   = 4'd2;
  localparam logic [3:0] REQ_LAT_WR   = 4'd3;
  localparam logic [3:0] REQ_ADDR_HI  = 4'd4;
  localparam logic [3:0] REQ_ADDR_LO  = 4'd5;
  localparam logic [3:0] REQ_MASK     = 4'd6;
  localparam logic [3:0] REQ_PAL_RD   = 4'd7;
  localparam logic [3:0] REQ_PAL_WR   = 4'd8;
  localparam logic [3:0] REQ_BANK     = 4'd9;
  localparam logic [3:0] REQ_PIXEL    = 4'd10;
  localparam logic [3:0] REQ_SCAN_CAP = 4'd11;
  localparam logic [3:0] REQ_SCAN_RD  = 4'd12;

  localparam logic CFG_MASKED_MODE = 1'b0;
  localparam logic CFG_SCREEN_FLIP = 1'b1;

  localparam logic [7:0]       LED_MASK  = 8'hfc;
  localparam logic [7:0]       MASK_INIT = 8'hff;
  localparam logic [FS_AW-1:0] FLIP_MASK = 16'hffff;

  localparam logic [7:0] LEVEL_TABLE [16] = '{
    8'h00, 8'h12, 8'h24, 8'h49,
    8'h12, 8'h24, 8'h49, 8'h92,
    8'h5b, 8'h6d, 8'h92, 8'hdb,
    8'h7f, 8'h91, 8'hb6, 8'hff
  };

  typedef struct packed {
    logic [3:0]  req_type;
    logic [14:0] bus_addr;
    logic [7:0]  bus_data;
    logic [13:0] crtc_ma;
    logic [4:0]  crtc_ra;
    logic [7:0]  pixel_x;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] led_bits;
  } rsp_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_FRD,
    K_FWR,
    K_PRD,
    K_PWR,
    K_PIX
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [FS_AW-1:0]   fs_addr;
    logic [PAL_AW-1:0]  pal_addr;
    logic [BANK_W-1:0]  bank;
    logic [7:0]         data;
    logic [7:0]         mask;
    logic               masked;
    logic [7:0]         rd;
    logic [7:0]         led;
  } entry_t;

endpackage

// File: rtl/lvp_queue.sv
// ----------------------------------------------------------------------------
// lvp_queue: decoded request queue
// A small FIFO that decouples the front end from the memory back end.
// ----------------------------------------------------------------------------
module lvp_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lvp_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output lvp_pkg::entry_t head,
  output logic            empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lvp_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/lvp_front.sv
// ----------------------------------------------------------------------------
// lvp_front: request front end
// Accepts requests, updates the address, mask, bank, LED and scanline
// latches, and forms a decoded request with resolved addresses.
// ----------------------------------------------------------------------------
module lvp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  lvp_pkg::req_t   req,
  input  logic            cfg_wen,
  input  logic            cfg_index,
  input  logic            cfg_data,
  input  logic            q_full,
  input  logic            clearing,
  output logic            push,
  output lvp_pkg::entry_t push_entry
);

  logic       masked_mode;
  logic       screen_flip;
  logic [7:0] address_high;
  logic [7:0] address_low;
  logic [7:0] write_mask;
  logic [1:0] active_bank;
  logic [7:0] led_register;
  logic [7:0] scanline_register;

  logic [7:0] address_high_next;
  logic [7:0] address_low_next;
  logic [7:0] write_mask_next;
  logic [1:0] active_bank_next;
  logic [7:0] led_register_next;
  logic [7:0] scanline_register_next;
  logic [lvp_pkg::FS_AW-1:0] pixel_addr;

  assign req_stall = q_full || clearing;
  assign push      = req_valid && !req_stall;

  assign pixel_addr = {req.crtc_ma[9:5], req.crtc_ra[2:0], req.pixel_x}
                      ^ (screen_flip ? lvp_pkg::FLIP_MASK : '0);

  always_comb begin
    address_high_next      = address_high;
    address_low_next       = address_low;
    write_mask_next        = write_mask;
    active_bank_next       = active_bank;
    led_register_next      = led_register;
    scanline_register_next = scanline_register;

    push_entry          = '0;
    push_entry.kind     = lvp_pkg::K_NONE;
    push_entry.pal_addr = req.bus_addr[lvp_pkg::PAL_AW-1:0];
    push_entry.bank     = active_bank;
    push_entry.data     = req.bus_data;
    push_entry.mask     = write_mask;
    push_entry.masked   = masked_mode;

    unique case (req.req_type)
      lvp_pkg::REQ_WIN_RD: begin
        push_entry.kind    = lvp_pkg::K_FRD;
        push_entry.fs_addr = {address_high[7], req.bus_addr};
      end
      lvp_pkg::REQ_WIN_WR: begin
        push_entry.kind    = lvp_pkg::K_FWR;
        push_entry.fs_addr = {address_high[7], req.bus_addr};
      end
      lvp_pkg::REQ_LAT_RD: begin
        push_entry.kind    = lvp_pkg::K_FRD;
        push_entry.fs_addr = {address_high, address_low};
      end
      lvp_pkg::REQ_LAT_WR: begin
        push_entry.kind    = lvp_pkg::K_FWR;
        push_entry.fs_addr = {address_high, address_low};
      end
      lvp_pkg::REQ_ADDR_HI:  address_high_next = req.bus_data;
      lvp_pkg::REQ_ADDR_LO:  address_low_next  = req.bus_data;
      lvp_pkg::REQ_MASK:     write_mask_next   = req.bus_data;
      lvp_pkg::REQ_PAL_RD:   push_entry.kind   = lvp_pkg::K_PRD;
      lvp_pkg::REQ_PAL_WR:   push_entry.kind   = lvp_pkg::K_PWR;
      lvp_pkg::REQ_BANK: begin
        active_bank_next  = req.bus_data[1:0];
        led_register_next = ~req.bus_data & lvp_pkg::LED_MASK;
      end
      lvp_pkg::REQ_PIXEL: begin
        push_entry.kind    = lvp_pkg::K_PIX;
        push_entry.fs_addr = pixel_addr;
      end
      lvp_pkg::REQ_SCAN_CAP: scanline_register_next = {req.crtc_ma[9:5], req.crtc_ra[2:0]};
      lvp_pkg::REQ_SCAN_RD:  push_entry.rd = scanline_register;
      default: ;
    endcase

    push_entry.led = led_register_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      masked_mode       <= 1'b0;
      screen_flip       <= 1'b0;
      address_high      <= '0;
      address_low       <= '0;
      write_mask        <= lvp_pkg::MASK_INIT;
      active_bank       <= '0;
      led_register      <= '0;
      scanline_register <= '0;
    end else begin
      if (cfg_wen) begin
        if (cfg_index == lvp_pkg::CFG_MASKED_MODE) begin
          masked_mode <= cfg_data;
        end
        if (cfg_index == lvp_pkg::CFG_SCREEN_FLIP) begin
          screen_flip <= cfg_data;
        end
      end
      if (push) begin
        address_high      <= address_high_next;
        address_low       <= address_low_next;
        write_mask        <= write_mask_next;
        active_bank       <= active_bank_next;
        led_register      <= led_register_next;
        scanline_register <= scanline_register_next;
      end
    end
  end

endmodule

// File: rtl/lvp_back.sv
// ----------------------------------------------------------------------------
// lvp_back: memory back end
// Carries out decoded requests against the frame store and palette RAM,
// converts palette entries to RGB and holds the result register.
// ----------------------------------------------------------------------------
module lvp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  lvp_pkg::entry_t head,
  output logic            pop,
  output logic            clearing,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output lvp_pkg::rsp_t   rsp
);

  typedef enum logic [5:0] {
    B_CLR  = 6'b000001,
    B_IDLE = 6'b000010,
    B_MEM  = 6'b000100,
    B_MRG  = 6'b001000,
    B_PAL  = 6'b010000,
    B_DONE = 6'b100000
  } state_t;

  localparam int FS_DEPTH  = 1 << lvp_pkg::FS_AW;
  localparam int PAL_DEPTH = 1 << lvp_pkg::PAL_AW;

  logic [7:0] frame_store [FS_DEPTH];
  logic [7:0] palette_store [PAL_DEPTH];

  state_t                     state;
  state_t                     state_next;
  logic [lvp_pkg::FS_AW-1:0]  clr_cnt;
  lvp_pkg::entry_t            cur;
  logic [7:0]                 fs_q;
  logic [7:0]                 pal_q;

  logic                       fs_we;
  logic [lvp_pkg::FS_AW-1:0]  fs_waddr;
  logic [7:0]                 fs_wdata;
  logic                       fs_re;
  logic                       pal_we;
  logic [lvp_pkg::PAL_AW-1:0] pal_waddr;
  logic [7:0]                 pal_wdata;
  logic                       pal_re;
  logic [lvp_pkg::PAL_AW-1:0] pal_raddr;
  logic                       load;
  lvp_pkg::rsp_t              rsp_next;

  assign clearing = (state == B_CLR);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    fs_we      = 1'b0;
    fs_waddr   = cur.fs_addr;
    fs_wdata   = cur.data;
    fs_re      = 1'b0;
    pal_we     = 1'b0;
    pal_waddr  = cur.pal_addr;
    pal_wdata  = cur.data;
    pal_re     = 1'b0;
    pal_raddr  = cur.pal_addr;

    unique case (state)
      B_CLR: begin
        fs_we     = 1'b1;
        fs_waddr  = clr_cnt;
        fs_wdata  = '0;
        pal_we    = 1'b1;
        pal_waddr = clr_cnt[lvp_pkg::PAL_AW-1:0];
        pal_wdata = '0;
        if (clr_cnt == lvp_pkg::FS_AW'(FS_DEPTH - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        pop = !q_empty;
        if (!q_empty) begin
          state_next = B_MEM;
        end
      end
      B_MEM: begin
        state_next = B_DONE;
        case (cur.kind)
          lvp_pkg::K_FRD: fs_re = 1'b1;
          lvp_pkg::K_FWR: begin
            if (cur.masked) begin
              fs_re      = 1'b1;
              state_next = B_MRG;
            end else begin
              fs_we = 1'b1;
            end
          end
          lvp_pkg::K_PRD: pal_re = 1'b1;
          lvp_pkg::K_PWR: pal_we = 1'b1;
          lvp_pkg::K_PIX: begin
            fs_re      = 1'b1;
            state_next = B_PAL;
          end
          default: ;
        endcase
      end
      B_MRG: begin
        fs_we      = 1'b1;
        fs_wdata   = (fs_q & ~cur.mask) | (cur.data & cur.mask);
        state_next = B_DONE;
      end
      B_PAL: begin
        pal_re     = 1'b1;
        pal_raddr  = {cur.bank, fs_q[lvp_pkg::PEN_W-1:0]};
        state_next = B_DONE;
      end
      B_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          load       = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    rsp_next          = '0;
    rsp_next.led_bits = cur.led;
    case (cur.kind)
      lvp_pkg::K_FRD: rsp_next.read_data = fs_q;
      lvp_pkg::K_PRD: rsp_next.read_data = pal_q;
      lvp_pkg::K_PIX: begin
        rsp_next.red   = lvp_pkg::LEVEL_TABLE[{pal_q[7:6], pal_q[1:0]}];
        rsp_next.green = lvp_pkg::LEVEL_TABLE[{pal_q[5:4], pal_q[1:0]}];
        rsp_next.blue  = lvp_pkg::LEVEL_TABLE[{pal_q[3:2], pal_q[1:0]}];
      end
      default: rsp_next.read_data = cur.rd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      frame_store[fs_waddr] <= fs_wdata;
    end
    if (fs_re) begin
      fs_q <= frame_store[cur.fs_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette_store[pal_waddr] <= pal_wdata;
    end
    if (pal_re) begin
      pal_q <= palette_store[pal_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (load) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/latched_video_ram_and_palette_top.sv
// ----------------------------------------------------------------------------
// latched_video_ram_and_palette_top: video RAM and palette subsystem
// Frame store with window and latched access, masked writes, banked palette
// with RGB conversion, and scanline capture.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+---------------------------
//   request | req_valid, req_stall  | req (lvp_pkg::req_t)
//   result  | rsp_valid, rsp_stall  | rsp (lvp_pkg::rsp_t)
//   config  | cfg_wen               | cfg_index, cfg_data
//
// Each request passes through the back-end states idle, memory access and
// done; a masked frame store write adds a merge state, a pixel fetch a
// palette lookup. The front end takes one request per cycle while the queue
// has room. After reset a clearing pass over every frame store address
// zeroes both memories and no request is accepted until it ends. A stalled
// result holds the back end; the queue then fills and stalls the requests.
// ----------------------------------------------------------------------------
module latched_video_ram_and_palette_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lvp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lvp_pkg::rsp_t rsp,
  input  logic          cfg_wen,
  input  logic          cfg_index,
  input  logic          cfg_data
);

  logic            q_full;
  logic            q_empty;
  logic            push;
  logic            pop;
  logic            clearing;
  lvp_pkg::entry_t push_entry;
  lvp_pkg::entry_t head;

  lvp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .clearing   (clearing),
    .push       (push),
    .push_entry (push_entry)
  );

  lvp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  lvp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .clearing  (clearing),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("request queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("request queue read while empty");

  a_quiet_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !rsp_valid && !push)
    else $error("activity during memory clearing pass");

endmodule
